### rtl/core/thpa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// thpa_pkg
// Shared types and constants of the TDMA hyperperiod accumulator.
// ----------------------------------------------------------------------------
package thpa_pkg;

    // configuration register widths and reset values
    localparam int ST_W   = 16;
    localparam int SPE_W  = 11;
    localparam int PROD_W = ST_W + SPE_W;   // slot_time * slots_per_epoch

    localparam logic [ST_W-1:0]  ST_RESET  = 16'd1;
    localparam logic [SPE_W-1:0] SPE_RESET = 11'd5;

    // APB port geometry: two registers on a 32-bit data bus at byte addresses 0 and 4
    localparam int APB_AW      = 3;
    localparam int APB_DW      = 32;
    localparam int REG_SEL_BIT = 2;

    typedef enum logic [0:0] {
        REG_SLOT_TIME       = 1'b0,
        REG_SLOTS_PER_EPOCH = 1'b1
    } t_reg_idx;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIV_EPOCH,
        ST_DIV_SLOT,
        ST_LCM_START,
        ST_GCD,
        ST_GCD_SCALE,
        ST_DIV_Q,
        ST_MUL,
        ST_DONE
    } t_state;

endpackage

### rtl/core/thpa_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// thpa_chan_if / thpa_res_if
// Valid/ready channels carrying channel descriptors in and results out.
// ----------------------------------------------------------------------------
interface thpa_chan_if #(
    parameter int W = 31
);
    logic         valid;
    logic         ready;
    logic         first_of_set;
    logic [W-1:0] channel_period;
    logic [W-1:0] send_duration;

    modport source (output valid, first_of_set, channel_period, send_duration,
                    input ready);
    modport sink   (input valid, first_of_set, channel_period, send_duration,
                    output ready);
endinterface

interface thpa_res_if #(
    parameter int W = 31
);
    logic         valid;
    logic         ready;
    logic [W-1:0] epoch_period;
    logic [W-1:0] slots_needed;
    logic [W-1:0] hyperperiod;
    logic         overflowed;

    modport source (output valid, epoch_period, slots_needed, hyperperiod, overflowed,
                    input ready);
    modport sink   (input valid, epoch_period, slots_needed, hyperperiod, overflowed,
                    output ready);
endinterface

### rtl/core/thpa_apb_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// thpa_apb_regs
// APB register file for slot_time and slots_per_epoch; presents the values
// used by the datapath with zero mapped to one.
// ----------------------------------------------------------------------------
module thpa_apb_regs
    import thpa_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    output logic [ST_W-1:0]   o_slot_time,
    output logic [SPE_W-1:0]  o_slots_per_epoch
);

    logic [ST_W-1:0]  r_slot_time;
    logic [SPE_W-1:0] r_slots_per_epoch;
    t_reg_idx         reg_idx;
    logic             wr_en;

    assign pready  = 1'b1;
    assign reg_idx = t_reg_idx'(paddr[REG_SEL_BIT]);
    assign wr_en   = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot_time       <= ST_RESET;
            r_slots_per_epoch <= SPE_RESET;
        end else if (wr_en) begin
            case (reg_idx)
                REG_SLOT_TIME:       r_slot_time       <= pwdata[ST_W-1:0];
                REG_SLOTS_PER_EPOCH: r_slots_per_epoch <= pwdata[SPE_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_SLOT_TIME:       prdata = APB_DW'(r_slot_time);
            REG_SLOTS_PER_EPOCH: prdata = APB_DW'(r_slots_per_epoch);
            default:             prdata = '0;
        endcase
    end

    assign o_slot_time       = (r_slot_time == '0) ? ST_W'(1) : r_slot_time;
    assign o_slots_per_epoch = (r_slots_per_epoch == '0) ? SPE_W'(1) : r_slots_per_epoch;

endmodule

### rtl/core/tdma_hyperperiod_accumulator.sv
`timescale 1ns / 1ps
// Sequence: the epoch divide and the slot divide, then straight to the result when the
//   hyperperiod goes to zero; otherwise also the binary gcd loop, the scaling back by
//   the common factors of two, the quotient divide and the multiply, which stops early
//   on saturation. Steps share one add/subtract unit.
// Flow: the input is not ready while busy, and a finished result waits in an output
//   register while the next is taken.
// Reset: synchronous active low; hyperperiod back to 1, overflow flag cleared.
// ----------------------------------------------------------------------------
// tdma_hyperperiod_accumulator
// Epoch period, slot count and running LCM hyperperiod per TDMA channel,
// computed by a sequencer around a single shared adder/subtractor.
// ----------------------------------------------------------------------------
module tdma_hyperperiod_accumulator
    import thpa_pkg::*;
#(
    parameter int VALUE_BITS = 31
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    thpa_chan_if.sink         i_chan,
    thpa_res_if.source        o_res,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    localparam int W  = VALUE_BITS;
    localparam int RW = ((W > PROD_W) ? W : PROD_W) + 1;   // remainder / accumulator
    localparam int UW = RW + 1;                            // shared unit width
    localparam int CW = $clog2(W);
    localparam logic [W-1:0] MASK = {W{1'b1}};

    logic [ST_W-1:0]  cfg_st;
    logic [SPE_W-1:0] cfg_spe;

    thpa_apb_regs u_regs (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready),
        .o_slot_time       (cfg_st),
        .o_slots_per_epoch (cfg_spe)
    );

    t_state        r_state, n_state;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [CW-1:0] r_k, n_k;
    logic          r_first, n_first;
    logic [W-1:0]  r_send, n_send;
    logic [W-1:0]  r_epoch, n_epoch;
    logic [W-1:0]  r_slots, n_slots;
    logic [W-1:0]  r_a, n_a;
    logic [W-1:0]  r_u, n_u;
    logic [W-1:0]  r_v, n_v;
    logic [W-1:0]  r_quo, n_quo;
    logic [RW-1:0] r_rem, n_rem;     // divider remainder, multiply accumulator
    logic [RW-1:0] r_dvs, n_dvs;
    logic [W-1:0]  r_lcm, n_lcm;
    logic          r_ovf, n_ovf;
    logic          r_out_valid, n_out_valid;
    logic [W-1:0]  r_o_epoch, n_o_epoch;
    logic [W-1:0]  r_o_slots, n_o_slots;
    logic [W-1:0]  r_o_hyper, n_o_hyper;
    logic          r_o_ovf, n_o_ovf;

    // shared adder/subtractor
    logic [UW-1:0] s_x, s_y, s_sum;
    logic          s_sub;

    logic [RW-1:0]   div_trial, div_rem;
    logic [W-1:0]    div_quo;
    logic            div_take, cnt_last, gcd_eq, gcd_neg, mul_ovf, in_xfer;
    logic [W-1:0]    lcm_a;
    logic [PROD_W-1:0] epoch_len;

    assign i_chan.ready = i_rst_n && (r_state == ST_IDLE);
    assign in_xfer      = i_chan.valid && i_chan.ready;

    assign o_res.valid        = r_out_valid;
    assign o_res.epoch_period = r_o_epoch;
    assign o_res.slots_needed = r_o_slots;
    assign o_res.hyperperiod  = r_o_hyper;
    assign o_res.overflowed   = r_o_ovf;

    assign epoch_len = PROD_W'(cfg_st) * PROD_W'(cfg_spe);

    always_comb begin
        s_x   = '0;
        s_y   = '0;
        s_sub = 1'b1;
        case (r_state)
            ST_DIV_EPOCH, ST_DIV_SLOT, ST_DIV_Q: begin
                s_x = UW'(div_trial);
                s_y = UW'(r_dvs);
            end
            ST_GCD: begin
                s_x = UW'(r_u);
                s_y = UW'(r_v);
            end
            ST_MUL: begin
                s_x   = UW'({r_rem[RW-2:0], 1'b0});
                s_y   = r_quo[W-1] ? UW'(r_epoch) : '0;
                s_sub = 1'b0;
            end
            default: ;
        endcase
    end

    assign s_sum = s_x + (s_sub ? ~s_y : s_y) + UW'(s_sub);

    // restoring division, one quotient bit per cycle
    assign div_trial = {r_rem[RW-2:0], r_quo[W-1]};
    assign div_take  = !s_sum[UW-1];
    assign div_rem   = div_take ? s_sum[RW-1:0] : div_trial;
    assign div_quo   = {r_quo[W-2:0], div_take};
    assign cnt_last  = (r_cnt == CW'(W - 1));

    assign gcd_eq  = (s_sum == '0);
    assign gcd_neg = s_sum[UW-1];
    assign mul_ovf = |s_sum[UW-1:W];
    assign lcm_a   = r_first ? W'(1) : r_lcm;

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_k         = r_k;
        n_first     = r_first;
        n_send      = r_send;
        n_epoch     = r_epoch;
        n_slots     = r_slots;
        n_a         = r_a;
        n_u         = r_u;
        n_v         = r_v;
        n_quo       = r_quo;
        n_rem       = r_rem;
        n_dvs       = r_dvs;
        n_lcm       = r_lcm;
        n_ovf       = r_ovf;
        n_out_valid = r_out_valid;
        n_o_epoch   = r_o_epoch;
        n_o_slots   = r_o_slots;
        n_o_hyper   = r_o_hyper;
        n_o_ovf     = r_o_ovf;

        if (r_out_valid && o_res.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (in_xfer) begin
                    n_first = i_chan.first_of_set;
                    n_send  = i_chan.send_duration;
                    n_quo   = i_chan.channel_period;
                    n_rem   = '0;
                    n_dvs   = RW'(epoch_len);
                    n_cnt   = '0;
                    n_state = ST_DIV_EPOCH;
                end
            end
            ST_DIV_EPOCH: begin
                n_quo = div_quo;
                n_rem = div_rem;
                n_cnt = r_cnt + CW'(1);
                if (cnt_last) begin
                    n_epoch = div_quo;
                    n_quo   = r_send;
                    n_rem   = '0;
                    n_dvs   = RW'(cfg_st);
                    n_cnt   = '0;
                    n_state = ST_DIV_SLOT;
                end
            end
            ST_DIV_SLOT: begin
                n_quo = div_quo;
                n_rem = div_rem;
                n_cnt = r_cnt + CW'(1);
                if (cnt_last) begin
                    // round up on a nonzero remainder
                    n_slots = div_quo + W'(|div_rem);
                    n_state = ST_LCM_START;
                end
            end
            ST_LCM_START: begin
                if (lcm_a == '0 || r_epoch == '0) begin
                    n_lcm   = '0;
                    n_state = ST_DONE;
                end else begin
                    n_a     = lcm_a;
                    n_u     = lcm_a;
                    n_v     = r_epoch;
                    n_k     = '0;
                    n_state = ST_GCD;
                end
            end
            ST_GCD: begin
                // binary gcd: strip common twos, halve a lone even value, subtract odd values
                if (gcd_eq) begin
                    n_state = ST_GCD_SCALE;
                end else if (!r_u[0] && !r_v[0]) begin
                    n_u = r_u >> 1;
                    n_v = r_v >> 1;
                    n_k = r_k + CW'(1);
                end else if (!r_u[0]) begin
                    n_u = r_u >> 1;
                end else if (!r_v[0]) begin
                    n_v = r_v >> 1;
                end else if (gcd_neg) begin
                    n_u = r_v;
                    n_v = r_u;
                end else begin
                    n_u = s_sum[W-1:0];
                end
            end
            ST_GCD_SCALE: begin
                if (r_k == '0) begin
                    n_quo   = r_a;
                    n_rem   = '0;
                    n_dvs   = RW'(r_u);
                    n_cnt   = '0;
                    n_state = ST_DIV_Q;
                end else begin
                    n_u = r_u << 1;
                    n_k = r_k - CW'(1);
                end
            end
            ST_DIV_Q: begin
                n_quo = div_quo;
                n_rem = div_rem;
                n_cnt = r_cnt + CW'(1);
                if (cnt_last) begin
                    n_rem   = '0;
                    n_cnt   = '0;
                    n_state = ST_MUL;
                end
            end
            ST_MUL: begin
                // shift-add of quotient times epoch, MSB first; stop on overflow
                n_quo = r_quo << 1;
                n_cnt = r_cnt + CW'(1);
                if (mul_ovf) begin
                    n_lcm   = MASK;
                    n_ovf   = 1'b1;
                    n_state = ST_DONE;
                end else begin
                    n_rem = s_sum[RW-1:0];
                    if (cnt_last) begin
                        n_lcm   = s_sum[W-1:0];
                        n_state = ST_DONE;
                    end
                end
            end
            ST_DONE: begin
                if (!r_out_valid || o_res.ready) begin
                    n_out_valid = 1'b1;
                    n_o_epoch   = r_epoch;
                    n_o_slots   = r_slots;
                    n_o_hyper   = r_lcm;
                    n_o_ovf     = r_ovf;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_lcm       <= W'(1);
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_lcm       <= n_lcm;
            r_ovf       <= n_ovf;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cnt     <= n_cnt;
        r_k       <= n_k;
        r_first   <= n_first;
        r_send    <= n_send;
        r_epoch   <= n_epoch;
        r_slots   <= n_slots;
        r_a       <= n_a;
        r_u       <= n_u;
        r_v       <= n_v;
        r_quo     <= n_quo;
        r_rem     <= n_rem;
        r_dvs     <= n_dvs;
        r_o_epoch <= n_o_epoch;
        r_o_slots <= n_o_slots;
        r_o_hyper <= n_o_hyper;
        r_o_ovf   <= n_o_ovf;
    end

endmodule

### rtl/core/thpa_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// thpa_checker
// Port-level assertions for the TDMA hyperperiod accumulator, bound to the top.
// ----------------------------------------------------------------------------
module thpa_checker #(
    parameter int VALUE_BITS = 31
) (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_in_valid,
    input logic                  i_in_ready,
    input logic                  i_out_valid,
    input logic                  i_out_ready,
    input logic [VALUE_BITS-1:0] i_hyperperiod,
    input logic                  i_overflowed
);

    logic       in_xfer, out_xfer;
    logic [1:0] r_pending;
    logic       r_ovf_seen;

    assign in_xfer  = i_in_valid && i_in_ready;
    assign out_xfer = i_out_valid && i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending  <= '0;
            r_ovf_seen <= 1'b0;
        end else begin
            case ({in_xfer, out_xfer})
                2'b10:   r_pending <= r_pending + 2'd1;
                2'b01:   r_pending <= r_pending - 2'd1;
                default: ;
            endcase
            if (out_xfer && i_overflowed) begin
                r_ovf_seen <= 1'b1;
            end
        end
    end

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_hyperperiod) && $stable(i_overflowed))
        else $error("result changed while stalled");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |=> !i_in_ready)
        else $error("input ready right after an accepted item");

    a_no_orphan_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> r_pending != 2'd0)
        else $error("result shown with no item outstanding");

    a_pending_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pending != 2'd3)
        else $error("more than two items outstanding");

    a_overflow_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_xfer && r_ovf_seen |-> i_overflowed)
        else $error("overflow flag dropped after being reported");

endmodule

bind tdma_hyperperiod_accumulator thpa_checker #(
    .VALUE_BITS (VALUE_BITS)
) u_thpa_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_chan.valid),
    .i_in_ready    (i_chan.ready),
    .i_out_valid   (o_res.valid),
    .i_out_ready   (o_res.ready),
    .i_hyperperiod (o_res.hyperperiod),
    .i_overflowed  (o_res.overflowed)
);
